// ===== hw/rtl/thc_pkg.sv =====
// Shared types and constants of the time window hit clusterer.
package thc_pkg;

  localparam int unsigned ModW    = 12;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned TrackW  = 31;
  localparam int unsigned EnergyW = 32;
  localparam int unsigned WidthW  = 32;
  localparam int unsigned CloseW  = TimeW + 1;

  // Register map: index is the word address.
  localparam logic REG_WINDOW_WIDTH = 1'b0;
  localparam logic [WidthW-1:0] WINDOW_WIDTH_RST = 32'd1000;

  typedef struct packed {
    logic [ModW-1:0]    module_id;
    logic [TimeW-1:0]   hit_time;
    logic [TrackW-1:0]  track_id;
    logic [EnergyW-1:0] hit_energy;
    logic               last_of_module;
  } hit_t;

  typedef struct packed {
    logic [ModW-1:0]    module_id;
    logic [TimeW-1:0]   cl_time;
    logic [TrackW-1:0]  track_id;
    logic [EnergyW-1:0] energy;
  } cluster_t;

  // What the cluster unit reports for the hit under work.
  typedef struct packed {
    logic     close_old;
    logic     flush;
    cluster_t old_cl;
    cluster_t cur_cl;
  } emit_t;

  typedef struct packed {
    cluster_t cl;
    logic     last;
  } out_item_t;

endpackage

// ===== hw/rtl/time_window_hit_clusterer_core.sv =====
// Top level of the time window hit clusterer: input stage, cluster unit, result queue, APB port.
//
// Usage:
//   Hits enter on the in_ channel (valid/ready), one transfer per hit, grouped
//   by module and time ordered within a module. Each hit yields zero, one or
//   two clusters on the out_ channel (valid/ready), one transfer per cluster;
//   out_last_of_run marks the final cluster a hit caused.
//   The window width register sits at APB address 0; write it only while idle.
// Path: a hit accepted on in_ passes the input register, then the result queue
//   register, before its first cluster shows on out_.
// Throughput: one hit per cycle while out_ready stays high and each hit emits at
//   most one cluster; a hit that emits two clusters needs two output transfers.
//   The two-entry result queue sets the figure: a hit moves on only once its clusters fit.
// Stall: when out_ready drops, the queue fills, the held hit waits in the
//   input register and in_ready falls; nothing is lost or repeated.
// Reset (rst_n low, synchronous): no cluster open, queue and input stage
//   empty, window width back to 1000 ticks.
module time_window_hit_clusterer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // hit channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [thc_pkg::ModW-1:0]        in_module_id,
  input  logic [thc_pkg::TimeW-1:0]       in_hit_time,
  input  logic [thc_pkg::TrackW-1:0]      in_track_id,
  input  logic [thc_pkg::EnergyW-1:0]     in_hit_energy,
  input  logic                            in_last_of_module,
  // cluster channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [thc_pkg::ModW-1:0]        out_module_id,
  output logic [thc_pkg::TimeW-1:0]       out_cluster_time,
  output logic [thc_pkg::TrackW-1:0]      out_cluster_track_id,
  output logic [thc_pkg::EnergyW-1:0]     out_cluster_energy,
  output logic                            out_last_of_run,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // ---------------- configuration ----------------
  logic [thc_pkg::WidthW-1:0] width_r;
  logic                       cfg_wr;
  logic                       reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == thc_pkg::REG_WINDOW_WIDTH);
  assign prdata  = (reg_idx == thc_pkg::REG_WINDOW_WIDTH) ? width_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= thc_pkg::WINDOW_WIDTH_RST;
    end else if (cfg_wr) begin
      width_r <= pwdata;
    end
  end

  // ---------------- input stage ----------------
  logic          s1_valid_r, s1_valid_nxt;
  thc_pkg::hit_t s1_hit_r;
  logic          in_xfer;
  logic          fire;

  assign in_ready = !s1_valid_r || fire;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Hold the hit until the cluster unit takes it.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_hit_r.module_id      <= in_module_id;
      s1_hit_r.hit_time       <= in_hit_time;
      s1_hit_r.track_id       <= in_track_id;
      s1_hit_r.hit_energy     <= in_hit_energy;
      s1_hit_r.last_of_module <= in_last_of_module;
    end
  end

  // ---------------- cluster unit ----------------
  thc_pkg::emit_t emit;

  thc_cluster_unit u_cluster (
    .clk          (clk),
    .rst_n        (rst_n),
    .window_width (width_r),
    .hit          (s1_hit_r),
    .hit_en       (fire),
    .emit         (emit)
  );

  // ---------------- result queue (two entries) ----------------
  thc_pkg::out_item_t q_r [2];
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;
  logic [1:0]         need;
  logic [1:0]         free;
  logic [1:0]         cnt_after;
  logic               wr0;
  thc_pkg::out_item_t item_a;
  thc_pkg::out_item_t item_b;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  always_comb begin
    // Results this hit produces: the closed cluster, then the flushed one.
    need      = {1'b0, emit.close_old} + {1'b0, emit.flush};
    free      = 2'd2 - cnt_r + {1'b0, pop};
    fire      = s1_valid_r && (free >= need);
    cnt_after = cnt_r - {1'b0, pop};
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr0       = rd_ptr_nxt ^ cnt_after[0];
    cnt_nxt   = cnt_after + (fire ? need : 2'd0);

    if (emit.close_old) begin
      item_a.cl   = emit.old_cl;
      item_a.last = !emit.flush;
    end else begin
      item_a.cl   = emit.cur_cl;
      item_a.last = 1'b1;
    end
    item_b.cl   = emit.cur_cl;
    item_b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (need != 2'd0)) begin
      q_r[wr0] <= item_a;
    end
    if (fire && (need == 2'd2)) begin
      q_r[~wr0] <= item_b;
    end
  end

  assign out_module_id        = q_r[rd_ptr_r].cl.module_id;
  assign out_cluster_time     = q_r[rd_ptr_r].cl.cl_time;
  assign out_cluster_track_id = q_r[rd_ptr_r].cl.track_id;
  assign out_cluster_energy   = q_r[rd_ptr_r].cl.energy;
  assign out_last_of_run      = q_r[rd_ptr_r].last;

endmodule

// ===== hw/rtl/thc_cluster_unit.sv =====
// Cluster state and per-hit join / close / flush decision.
module thc_cluster_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [thc_pkg::WidthW-1:0]    window_width,
  input  thc_pkg::hit_t                 hit,
  input  logic                          hit_en,
  output thc_pkg::emit_t                emit
);

  logic                           open_r, open_nxt;
  logic [thc_pkg::CloseW-1:0]     close_r, close_nxt;
  thc_pkg::cluster_t              cl_r, cl_nxt;
  logic                           late;
  logic                           close_old;
  logic                           join_cl;
  logic [thc_pkg::EnergyW:0]      sum;

  always_comb begin
    late      = {1'b0, hit.hit_time} > close_r;
    close_old = open_r && ((hit.module_id != cl_r.module_id) || late);
    join_cl   = open_r && !close_old;
    sum       = {1'b0, cl_r.energy} + {1'b0, hit.hit_energy};

    if (join_cl) begin
      cl_nxt.module_id = cl_r.module_id;
      // On equal track ids keep the hit that came first.
      if (hit.track_id < cl_r.track_id) begin
        cl_nxt.track_id = hit.track_id;
        cl_nxt.cl_time  = hit.hit_time;
      end else begin
        cl_nxt.track_id = cl_r.track_id;
        cl_nxt.cl_time  = cl_r.cl_time;
      end
      cl_nxt.energy = sum[thc_pkg::EnergyW] ? {thc_pkg::EnergyW{1'b1}}
                                            : sum[thc_pkg::EnergyW-1:0];
      close_nxt     = close_r;
    end else begin
      cl_nxt.module_id = hit.module_id;
      cl_nxt.track_id  = hit.track_id;
      cl_nxt.cl_time   = hit.hit_time;
      cl_nxt.energy    = hit.hit_energy;
      close_nxt = {1'b0, hit.hit_time} +
                  {{(thc_pkg::CloseW-thc_pkg::WidthW){1'b0}}, window_width};
    end
    open_nxt = !hit.last_of_module;

    emit.close_old = close_old;
    emit.flush     = hit.last_of_module;
    emit.old_cl    = cl_r;
    emit.cur_cl    = cl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (hit_en) begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_en) begin
      close_r <= close_nxt;
      cl_r    <= cl_nxt;
    end
  end

endmodule

// ===== sim/tb_time_window_hit_clusterer_core.sv =====
// Self-checking testbench of the time window hit clusterer core.
`timescale 1ns / 100ps

module tb_time_window_hit_clusterer_core;

  // Field widths of the block.
  localparam int unsigned ModW    = thc_pkg::ModW;
  localparam int unsigned TimeW   = thc_pkg::TimeW;
  localparam int unsigned TrackW  = thc_pkg::TrackW;
  localparam int unsigned EnergyW = thc_pkg::EnergyW;
  localparam int unsigned WidthW  = thc_pkg::WidthW;
  localparam int unsigned CloseW  = thc_pkg::CloseW;

  // Scoreboard: predicts the clusters of each transferred hit and checks results in order.
  class cluster_scoreboard;
    logic [WidthW-1:0]  window_width;
    bit                 cluster_open;
    logic [CloseW-1:0]  close_time;
    logic [TrackW-1:0]  best_track;
    logic [TimeW-1:0]   best_time;
    logic [EnergyW-1:0] energy_sum;
    logic [ModW-1:0]    cur_module;
    thc_pkg::out_item_t expected_clusters[$];
    int                 errors;
    int                 clusters_seen;

    function new();
      window_width = thc_pkg::WINDOW_WIDTH_RST;
      cluster_open = 0;
      close_time   = '0;
      best_track   = '0;
      best_time    = '0;
      energy_sum   = '0;
      cur_module   = '0;
      errors       = 0;
      clusters_seen = 0;
    endfunction

    function void push_cluster();
      thc_pkg::out_item_t item;
      item.cl.module_id = cur_module;
      item.cl.cl_time   = best_time;
      item.cl.track_id  = best_track;
      item.cl.energy    = energy_sum;
      item.last         = 1'b0;
      expected_clusters.push_back(item);
      cluster_open = 0;
    endfunction

    // Note a transferred hit; return how many clusters it emits.
    function int note_hit(thc_pkg::hit_t h);
      logic [EnergyW:0] sum;
      int n;
      n = 0;
      if (cluster_open && (h.module_id != cur_module || {1'b0, h.hit_time} > close_time)) begin
        push_cluster();
        n++;
      end
      if (cluster_open) begin
        sum = {1'b0, energy_sum} + {1'b0, h.hit_energy};
        if (h.track_id < best_track) begin
          best_track = h.track_id;
          best_time  = h.hit_time;
        end
        energy_sum = sum[EnergyW] ? '1 : sum[EnergyW-1:0];
      end else begin
        cluster_open = 1;
        cur_module   = h.module_id;
        close_time   = {1'b0, h.hit_time} + {{(CloseW-WidthW){1'b0}}, window_width};
        best_track   = h.track_id;
        best_time    = h.hit_time;
        energy_sum   = h.hit_energy;
      end
      if (h.last_of_module) begin
        push_cluster();
        n++;
      end
      if (n > 0) expected_clusters[$].last = 1'b1;
      return n;
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_cluster(thc_pkg::cluster_t got, logic got_last);
      thc_pkg::out_item_t want;
      clusters_seen++;
      if (expected_clusters.size() == 0) begin
        $error("cluster transfer with nothing expected: module %0h track %0h",
               got.module_id, got.track_id);
        errors++;
        return;
      end
      want = expected_clusters.pop_front();
      compare_field("out_module_id", 64'(want.cl.module_id), 64'(got.module_id));
      compare_field("out_cluster_time", 64'(want.cl.cl_time), 64'(got.cl_time));
      compare_field("out_cluster_track_id", 64'(want.cl.track_id), 64'(got.track_id));
      compare_field("out_cluster_energy", 64'(want.cl.energy), 64'(got.energy));
      compare_field("out_last_of_run", 64'(want.last), 64'(got_last));
    endfunction

    function int pending();
      return expected_clusters.size();
    endfunction
  endclass

  localparam int unsigned    RegStride  = 4;
  localparam int unsigned    HoldCycles = 300;
  localparam logic [TimeW-1:0] TimeMax  = '1;

  logic clk;
  logic rst_n;

  logic                 in_valid;
  logic                 in_ready;
  logic [ModW-1:0]      in_module_id;
  logic [TimeW-1:0]     in_hit_time;
  logic [TrackW-1:0]    in_track_id;
  logic [EnergyW-1:0]   in_hit_energy;
  logic                 in_last_of_module;

  logic                 out_valid;
  logic                 out_ready;
  logic [ModW-1:0]      out_module_id;
  logic [TimeW-1:0]     out_cluster_time;
  logic [TrackW-1:0]    out_cluster_track_id;
  logic [EnergyW-1:0]   out_cluster_energy;
  logic                 out_last_of_run;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  cluster_scoreboard sb;
  bit  no_idle;        // both sides run without gaps during this phase
  bit  hold_off_req;   // ask the receiver for one long stall
  int  hits_sent;
  int  double_hits;    // hits that closed one cluster and flushed their own
  int  width_settings;
  int  cfg_errors;

  time_window_hit_clusterer_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_module_id         (in_module_id),
    .in_hit_time          (in_hit_time),
    .in_track_id          (in_track_id),
    .in_hit_energy        (in_hit_energy),
    .in_last_of_module    (in_last_of_module),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_module_id        (out_module_id),
    .out_cluster_time     (out_cluster_time),
    .out_cluster_track_id (out_cluster_track_id),
    .out_cluster_energy   (out_cluster_energy),
    .out_last_of_run      (out_last_of_run),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Draw the wait before the next item; zero while a burst phase runs.
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Offer one hit and return at the edge where it transfers. Keep valid high
  // between back-to-back hits so valid never drops and rises in one step.
  task automatic send_hit(thc_pkg::hit_t h);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_module_id      <= h.module_id;
    in_hit_time       <= h.hit_time;
    in_track_id       <= h.track_id;
    in_hit_energy     <= h.hit_energy;
    in_last_of_module <= h.last_of_module;
    do @(posedge clk); while (!in_ready);
    if (sb.note_hit(h) == 2) double_hits++;
    hits_sent++;
  endtask

  task automatic hit(logic [ModW-1:0] m, logic [TimeW-1:0] t, logic [TrackW-1:0] trk,
                     logic [EnergyW-1:0] e, logic last);
    thc_pkg::hit_t h;
    h.module_id      = m;
    h.hit_time       = t;
    h.track_id       = trk;
    h.hit_energy     = e;
    h.last_of_module = last;
    send_hit(h);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the access edge.
  // Return to idle after the access.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, wait for every expected cluster, then idle on until the
  // last hit (which may emit nothing) has left the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the window width while idle, update the prediction and read it back.
  task automatic set_window(logic [WidthW-1:0] w);
    logic [31:0] rd;
    drain();
    apb_write(3'(thc_pkg::REG_WINDOW_WIDTH * RegStride), w);
    sb.window_width = w;
    width_settings++;
    apb_read(3'(thc_pkg::REG_WINDOW_WIDTH * RegStride), rd);
    if (rd !== w) begin
      $error("window_width readback: expected %0h, actual %0h", w, rd);
      cfg_errors++;
    end
  endtask

  function automatic logic [TrackW-1:0] rand_track();
    logic [31:0] r;
    r = $urandom;
    // Narrow range half the time so equal and smaller track ids meet often.
    return ($urandom_range(0, 1) == 0) ? TrackW'($urandom_range(0, 7)) : r[TrackW-1:0];
  endfunction

  function automatic logic [EnergyW-1:0] rand_energy();
    case ($urandom_range(0, 3))
      0:       return EnergyW'($urandom_range(0, 255));
      1:       return 32'hFFFF_FF00 | EnergyW'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) return TimeMax - TimeW'($urandom_range(0, 2000));
    return r[TimeW-1:0];
  endfunction

  // One module's worth of hits. A broken sequence may jump back in time,
  // switch module mid-way or leave out the end flag.
  task automatic send_sequence(bit broken, ref int sent);
    logic [ModW-1:0]  m;
    logic [TimeW-1:0] t;
    logic [63:0]      step;
    logic [WidthW-1:0] w;
    int               n_hits;
    bit               flag_end;
    bit               last;
    m        = ModW'($urandom);
    t        = rand_time();
    w        = sb.window_width;
    n_hits   = $urandom_range(1, 8);
    flag_end = broken ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) != 0);
    for (int i = 0; i < n_hits; i++) begin
      case ($urandom_range(0, 3))
        0:       step = 0;
        1:       step = 64'($urandom_range(0, w));
        2:       step = 64'(w) + 64'($urandom_range(1, 1000));
        default: step = 64'($urandom_range(0, 15));
      endcase
      if (i > 0) t = t + TimeW'(step);
      if (broken && $urandom_range(0, 3) == 0) t = t - TimeW'($urandom_range(1, 5000));
      if (broken && $urandom_range(0, 5) == 0) m = ModW'($urandom);
      last = flag_end && (i == n_hits - 1);
      hit(m, t, rand_track(), rand_energy(), last);
      sent++;
    end
  endtask

  task automatic run_random_phase(int n_items);
    thc_pkg::hit_t h;
    int   sent;
    int   kind;
    logic [63:0] r;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_sequence(1'b0, sent);
      end else if (kind <= 8) begin
        send_sequence(1'b1, sent);
      end else begin
        // Noise: a hit with every field drawn over its full range.
        r                = {$urandom, $urandom};
        h.module_id      = ModW'($urandom);
        h.hit_time       = r[TimeW-1:0];
        h.track_id       = TrackW'($urandom);
        h.hit_energy     = $urandom;
        h.last_of_module = 1'($urandom);
        send_hit(h);
        sent++;
      end
    end
  endtask

  // Receiver: stall a random number of cycles before each cluster, or one long
  // stretch on request so the result queue fills and in_ready falls.
  initial begin : receiver
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_gap();
      if (hold_off_req) begin
        hold_off_req = 0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_cluster({out_module_id, out_cluster_time, out_cluster_track_id,
                        out_cluster_energy}, out_last_of_run);
    end
  end

  // Watchdog: a hang or a lost cluster ends here.
  initial begin : watchdog
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] rd;
    int unsigned phase_widths[6];
    sb             = new();
    no_idle        = 0;
    hold_off_req   = 0;
    hits_sent      = 0;
    double_hits    = 0;
    width_settings = 1;
    cfg_errors     = 0;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_module_id      <= '0;
    in_hit_time       <= '0;
    in_track_id       <= '0;
    in_hit_energy     <= '0;
    in_last_of_module <= 1'b0;
    out_ready         <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed hits at the reset width of 1000 ticks.
    hit(12'd5, 48'd100, 31'd50, 32'd10, 1'b0);         // open
    hit(12'd5, 48'd1100, 31'd20, 32'd20, 1'b0);        // exactly at closing time: join
    hit(12'd5, 48'd1101, 31'd30, 32'd1, 1'b0);         // one past: close, open anew
    hit(12'd5, 48'd1050, 31'd30, 32'd2, 1'b0);         // back in time, equal track: join
    hit(12'd6, 48'd0, '1, '1, 1'b0);                   // module change without end flag
    hit(12'd6, 48'd5, '1, '1, 1'b0);                   // energy saturates
    hit(12'd6, 48'd10, 31'd0, 32'd1, 1'b1);            // join, then flush
    hit(12'd7, TimeMax, 31'd0, 32'd0, 1'b0);           // closing time past 48 bits
    hit(12'd7, TimeMax, 31'd1, 32'd0, 1'b0);
    hit('1, 48'd0, 31'd5, 32'd5, 1'b1);                // close old and flush own: two clusters
    hit(12'd0, 48'd0, 31'd0, 32'd0, 1'b1);             // single-hit cluster
    hit(12'd0, TimeMax, '1, 32'd7, 1'b0);
    hit(12'd0, 48'd0, 31'd3, 32'd8, 1'b1);

    // A write to the unused register slot must leave the width alone.
    drain();
    apb_write(3'(RegStride), $urandom);
    apb_read(3'(thc_pkg::REG_WINDOW_WIDTH * RegStride), rd);
    if (rd !== sb.window_width) begin
      $error("window_width after unused write: expected %0h, actual %0h", sb.window_width, rd);
      cfg_errors++;
    end

    // Zero width: only equal times share a cluster.
    set_window('0);
    hit(12'd9, 48'd500, 31'd3, 32'd1, 1'b0);
    hit(12'd9, 48'd500, 31'd2, 32'd1, 1'b0);
    hit(12'd9, 48'd501, 31'd4, 32'd1, 1'b0);
    hit(12'd9, 48'd501, 31'd4, 32'd1, 1'b1);

    // Widest window.
    set_window('1);
    hit(12'd10, 48'd0, 31'd1, 32'd1, 1'b0);
    hit(12'd10, 48'h0000_FFFF_FFFF, 31'd0, 32'd1, 1'b0);
    hit(12'd10, 48'h0001_0000_0000, 31'd2, 32'd1, 1'b0);
    hit(12'd10, TimeMax, 31'd2, 32'd1, 1'b1);
    hit(12'd11, TimeMax - 48'd5, 31'd9, 32'd3, 1'b1);

    // Random phases; hold the receiver off in one, run gap-free in two.
    phase_widths = '{32'd50, 32'd1000, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd5000};
    foreach (phase_widths[i]) begin
      set_window(phase_widths[i]);
      no_idle = (i == 1 || i == 4);
      if (i == 2) hold_off_req = 1;
      run_random_phase(200);
    end
    no_idle = 0;

    // Wait out every expected cluster and any stray late transfer.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d hits, %0d clusters, %0d window settings;",
             hits_sent, sb.clusters_seen, width_settings);
    $display("%0d hits closed a cluster and flushed their own.", double_hits);
    if (sb.errors == 0 && cfg_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/thc_pkg.sv
hw/rtl/thc_cluster_unit.sv
hw/rtl/time_window_hit_clusterer_core.sv
sim/tb_time_window_hit_clusterer_core.sv
